// ===== rtl/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

  localparam int CAPACITY = 16;
  localparam int CFG_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_RESET = 16;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CAP_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } lkv_state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic update;
  } lkv_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lkv_datapath.sv =====
`default_nettype none

module lkv_datapath
  import lkv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lkv_cmd_t         cmd,
  input  wire logic             in_mode,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic             cfg_write,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  res_hit,
  output logic [VAL_W-1:0]      res_value
);

  logic              mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  wval_r;
  logic [CFG_W-1:0]  cap_r;
  logic              hit_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_hit_r;
  logic [VAL_W-1:0]  out_value_r;

  logic [KEY_W-1:0]  entry_key_r   [CAPACITY];
  logic [VAL_W-1:0]  entry_value_r [CAPACITY];
  logic              entry_valid_r [CAPACITY];
  logic [RANK_W-1:0] entry_rank_r  [CAPACITY];
  logic              entry_valid_nxt [CAPACITY];
  logic [RANK_W-1:0] entry_rank_nxt  [CAPACITY];

  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] keep_vec;
  logic                match_found;
  logic [IDX_W-1:0]    match_idx;
  logic [IDX_W-1:0]    slot_idx;
  logic [CMP_W-1:0]    cap_wide;
  logic [CMP_W-1:0]    cap_eff;
  logic [RANK_W-1:0]   limit;
  logic [RANK_W-1:0]   hit_rank;

  always_comb begin
    cap_wide = CMP_W'(cap_r);
    if (cap_wide == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_wide > CMP_W'(CAPACITY)) begin
      cap_eff = CMP_W'(CAPACITY);
    end else begin
      cap_eff = cap_wide;
    end
    limit = RANK_W'(cap_eff - CMP_W'(1));
  end

  always_comb begin
    match_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_vec[i] = entry_valid_r[i] && (entry_key_r[i] == key_r);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_idx = IDX_W'(i);
      end
    end
    match_found = |match_vec;
  end

  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      keep_vec[i] = entry_valid_r[i] && (entry_rank_r[i] < limit);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!keep_vec[i]) begin
        slot_idx = IDX_W'(i);
      end
    end
  end

  assign hit_rank = entry_rank_r[idx_r];

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entry_valid_nxt[i] = entry_valid_r[i];
      entry_rank_nxt[i]  = entry_rank_r[i];
      if (hit_r) begin
        if (IDX_W'(i) == idx_r) begin
          entry_rank_nxt[i] = '0;
        end else if (entry_valid_r[i] && (entry_rank_r[i] < hit_rank)) begin
          entry_rank_nxt[i] = entry_rank_r[i] + RANK_W'(1);
        end
      end else if (mode_r == MODE_PUT) begin
        if (keep_vec[i]) begin
          entry_valid_nxt[i] = 1'b1;
          entry_rank_nxt[i]  = entry_rank_r[i] + RANK_W'(1);
        end else begin
          entry_valid_nxt[i] = (IDX_W'(i) == slot_idx);
          entry_rank_nxt[i]  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CFG_W'(CAP_RESET);
      for (int i = 0; i < CAPACITY; i++) begin
        entry_valid_r[i] <= 1'b0;
        entry_rank_r[i]  <= '0;
      end
    end else begin
      if (cfg_write) begin
        cap_r <= cfg_data;
      end
      if (cmd.update) begin
        for (int i = 0; i < CAPACITY; i++) begin
          entry_valid_r[i] <= entry_valid_nxt[i];
          entry_rank_r[i]  <= entry_rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      wval_r <= in_value;
    end
    if (cmd.match) begin
      hit_r <= match_found;
      idx_r <= match_idx;
    end
    if (cmd.update) begin
      out_hit_r <= hit_r;
      if (mode_r == MODE_PUT) begin
        out_value_r <= '0;
        if (hit_r) begin
          entry_value_r[idx_r] <= wval_r;
        end else begin
          entry_key_r[slot_idx]   <= key_r;
          entry_value_r[slot_idx] <= wval_r;
        end
      end else if (hit_r) begin
        out_value_r <= entry_value_r[idx_r];
      end else begin
        out_value_r <= MISS_VALUE;
      end
    end
  end

  assign res_hit   = out_hit_r;
  assign res_value = out_value_r;

endmodule

`default_nettype wire

// ===== rtl/lkv_ctrl.sv =====
`default_nettype none

module lkv_ctrl
  import lkv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output lkv_cmd_t  cmd
);

  lkv_state_t state_r;
  lkv_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.match   = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MATCH))
    else $error("accepted word did not start a key compare");
  a_match_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MATCH) |=> (state_r == ST_UPDATE))
    else $error("key compare not followed by update");
  a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> (!out_valid_r || out_ready))
    else $error("update overwrote a result word not yet taken");
  a_update_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("update did not present a result word");
`endif

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache_top.sv =====
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement over
// sixteen entries; each input word is a get or a put and yields one result word.
// An item passes through the controller states in order: it is accepted and
// captured in the idle state, its key is compared in parallel across all entries
// in the match state, and ranks and entries are updated and the result is
// registered in the update state. A new word is accepted only in the idle state,
// so the cache takes no new word before it is through with the last one. The
// result waits in an output register, and the next word is accepted while it
// waits; its update step stalls only while the earlier result has not been taken.
// The store is empty after reset with no clearing pass. The capacity register is
// always ready and should be written only while the cache is idle.

module lru_key_value_cache_top
  import lkv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_mode,
  input  wire logic signed [KEY_W-1:0] in_lookup_key,
  input  wire logic signed [VAL_W-1:0] in_write_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_hit,
  output logic signed [VAL_W-1:0]      out_read_value,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_W-1:0]        cfg_capacity
);

  lkv_cmd_t         cmd;
  logic [VAL_W-1:0] res_value;

  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkv_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_mode   (in_mode),
    .in_key    (in_lookup_key),
    .in_value  (in_write_value),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_capacity),
    .res_hit   (out_hit),
    .res_value (res_value)
  );

  assign out_read_value = res_value;

endmodule

`default_nettype wire
